// File: rtl/skt_pkg.sv
// shared types and constants for the sorted key table engine
package skt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_W       = 20;
    localparam int NUM_W       = 10;

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_PURGE  = 2'd2;
    localparam logic [1:0] OP_FREE   = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [0:0] REG_ENTRY_MIN = 1'd0;
    localparam logic [0:0] REG_ENTRY_MAX = 1'd1;

    typedef struct packed {
        logic [1:0]       operation;
        logic [NUM_W-1:0] plan_number;
        logic [NUM_W-1:0] entry_number;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [8:0]       position;
        logic [1:0]       status;
        logic [8:0]       removed_count;
        logic [NUM_W-1:0] free_number;
    } rsp_t;

    // controller to datapath commands
    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,      // capture request, compute keys
        CMD_BS_INIT,   // lo=0 hi=count, target chosen by sel
        CMD_BS_READ,   // issue read at mid
        CMD_BS_STEP,   // compare read data, narrow range
        CMD_BS_END,    // latch search bound, set up shift or scan pointer
        CMD_SH_READ,   // read one entry for a shift
        CMD_SH_WRITE,  // write the shifted entry
        CMD_INS_WRITE, // write new key at insert point
        CMD_PURGE_END, // drop purged keys from the count
        CMD_SCAN_READ, // read entry for first-free
        CMD_SCAN_STEP  // check entry for first-free
    } cmd_e;

    typedef struct packed {
        cmd_e cmd;
        logic sel;     // search target: 0 request key or start key, 1 end key
    } ctl_t;

    typedef struct packed {
        logic bs_done;
        logic hit;
        logic full;
        logic sh_done;
        logic scan_done;
        logic [1:0] operation;
    } sts_t;

endpackage

// File: rtl/skt_if.sv
// valid/ready channel interface
interface skt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/skt_ram.sv
// generic single port ram with registered read
module skt_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one address per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

// File: rtl/skt_datapath.sv
// datapath: key registers, search bounds, shift pointer, table memory
module skt_datapath #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  skt_pkg::ctl_t             ctl,
    output skt_pkg::sts_t             sts,
    input  skt_pkg::req_t             req,
    input  logic [skt_pkg::NUM_W-1:0] entry_min,
    input  logic [skt_pkg::NUM_W-1:0] entry_max,
    output skt_pkg::rsp_t             rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int KW = skt_pkg::KEY_W;

    logic [1:0]    op_reg;
    logic [KW-1:0] key_reg;
    logic [KW-1:0] skey_reg;
    logic [KW-1:0] ekey_reg;
    logic          full_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] lo_reg, hi_reg;
    logic [CW-1:0] s_reg, e_reg;
    logic [CW-1:0] ptr_reg;
    logic [KW-1:0] want_reg;
    logic [KW-1:0] r_reg;
    logic          rfound_reg;
    logic          hit_reg;
    logic          sel_reg;

    logic          we;
    logic [AW-1:0] addr;
    logic [KW-1:0] wdata;
    logic [KW-1:0] rdata;
    logic [CW-1:0] mid;
    logic [CW-1:0] n_rm;
    logic [KW-1:0] target;
    logic [KW-1:0] plan_base;
    logic [KW-1:0] offs;
    logic [KW-1:0] rfin;
    logic          is_purge;

    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign target    = sel_reg ? ekey_reg : (op_reg[1] ? skey_reg : key_reg);
    assign n_rm      = e_reg - s_reg;
    assign plan_base = KW'(req.plan_number) * KW'(1000);
    assign is_purge  = (op_reg == skt_pkg::OP_PURGE);

    // entry number minus one of a key in the plan range: offset 999 is entry 0 of the next plan
    assign offs = rdata - skey_reg;

    // memory address and write selection
    always_comb
    begin
        we    = 1'b0;
        addr  = mid[AW-1:0];
        wdata = rdata;
        case (ctl.cmd)
            skt_pkg::CMD_SH_READ:
                addr = is_purge ? ptr_reg[AW-1:0] : AW'(ptr_reg - CW'(1));
            skt_pkg::CMD_SH_WRITE:
            begin
                we   = 1'b1;
                addr = is_purge ? AW'(ptr_reg - n_rm) : ptr_reg[AW-1:0];
            end
            skt_pkg::CMD_INS_WRITE:
            begin
                we    = 1'b1;
                addr  = lo_reg[AW-1:0];
                wdata = key_reg;
            end
            skt_pkg::CMD_SCAN_READ:
                addr = ptr_reg[AW-1:0];
            default:
                addr = mid[AW-1:0];
        endcase
    end

    skt_ram #(.WIDTH(KW), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    // key count
    always_comb
    begin
        count_next = count_reg;
        case (ctl.cmd)
            skt_pkg::CMD_INS_WRITE: count_next = count_reg + CW'(1);
            skt_pkg::CMD_PURGE_END: count_next = count_reg - n_rm;
            default:                count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // first-free result before limit check
    assign rfin = rfound_reg ? r_reg : KW'(n_rm) + KW'(1);

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (ctl.cmd)
            skt_pkg::CMD_LOAD:
            begin
                op_reg     <= req.operation;
                key_reg    <= plan_base + KW'(req.entry_number);
                skey_reg   <= plan_base + KW'(1);
                ekey_reg   <= plan_base + KW'(1001);
                full_reg   <= (count_reg >= CW'(TABLE_DEPTH));
                rfound_reg <= 1'b0;
                r_reg      <= '0;
                want_reg   <= KW'(1);
            end
            skt_pkg::CMD_BS_INIT:
            begin
                lo_reg  <= '0;
                hi_reg  <= count_reg;
                hit_reg <= 1'b0;
                sel_reg <= ctl.sel;
            end
            skt_pkg::CMD_BS_STEP:
            begin
                if (rdata < target)
                    lo_reg <= mid + CW'(1);
                else
                begin
                    hi_reg  <= mid;
                    hit_reg <= (rdata == target);
                end
            end
            skt_pkg::CMD_BS_END:
            begin
                // start search gives s and the insert shift start, end search gives e
                if (!sel_reg)
                begin
                    s_reg   <= lo_reg;
                    ptr_reg <= count_reg;
                end
                else
                begin
                    e_reg   <= lo_reg;
                    ptr_reg <= is_purge ? lo_reg : s_reg;
                end
            end
            skt_pkg::CMD_SH_WRITE:
            begin
                if (is_purge)
                    ptr_reg <= ptr_reg + CW'(1);
                else
                    ptr_reg <= ptr_reg - CW'(1);
            end
            skt_pkg::CMD_SCAN_STEP:
            begin
                if (!rfound_reg && offs != KW'(999) && offs >= want_reg)
                begin
                    rfound_reg <= 1'b1;
                    r_reg      <= want_reg;
                end
                ptr_reg  <= ptr_reg + CW'(1);
                want_reg <= want_reg + KW'(1);
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb
    begin
        sts.bs_done   = (lo_reg == hi_reg);
        sts.hit       = hit_reg && (lo_reg < count_reg);
        sts.full      = full_reg;
        sts.sh_done   = is_purge ? (ptr_reg >= count_reg) : (ptr_reg == lo_reg);
        sts.scan_done = (ptr_reg == e_reg) || rfound_reg;
        sts.operation = op_reg;
    end

    // result formation
    always_comb
    begin
        rsp = '0;
        case (op_reg)
            skt_pkg::OP_FIND:
            begin
                rsp.found    = sts.hit;
                rsp.position = 9'(lo_reg);
            end
            skt_pkg::OP_INSERT:
            begin
                rsp.found    = sts.hit;
                rsp.position = 9'(lo_reg);
                if (sts.hit)
                    rsp.status = skt_pkg::ST_DUP;
                else if (full_reg)
                    rsp.status = skt_pkg::ST_FULL;
            end
            skt_pkg::OP_PURGE:
            begin
                rsp.position      = 9'(s_reg);
                rsp.removed_count = 9'(n_rm);
            end
            skt_pkg::OP_FREE:
            begin
                if (rfin >= KW'(entry_min) && rfin <= KW'(entry_max))
                    rsp.free_number = rfin[skt_pkg::NUM_W-1:0];
            end
            default: ;
        endcase
    end
endmodule

// File: rtl/skt_ctrl.sv
// controller state machine
module skt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  skt_pkg::sts_t sts,
    output skt_pkg::ctl_t ctl
);
    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_BS_READ, S_BS_STEP,
        S_SH_READ, S_SH_WRITE, S_INS, S_SC_READ, S_SC_STEP, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg, sel_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        ctl.cmd    = skt_pkg::CMD_IDLE;
        ctl.sel    = sel_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    ctl.cmd    = skt_pkg::CMD_LOAD;
                    sel_next   = 1'b0;
                    state_next = S_INIT;
                end
            S_INIT:
            begin
                ctl.cmd    = skt_pkg::CMD_BS_INIT;
                state_next = S_BS_READ;
            end
            S_BS_READ:
                if (!sts.bs_done)
                begin
                    ctl.cmd    = skt_pkg::CMD_BS_READ;
                    state_next = S_BS_STEP;
                end
                else
                begin
                    ctl.cmd = skt_pkg::CMD_BS_END;
                    if (sts.operation == skt_pkg::OP_FIND)
                        state_next = S_DONE;
                    else if (sts.operation == skt_pkg::OP_INSERT)
                        state_next = (sts.hit || sts.full) ? S_DONE : S_SH_READ;
                    else if (!sel_reg)
                    begin
                        sel_next   = 1'b1;
                        state_next = S_INIT;
                    end
                    else if (sts.operation == skt_pkg::OP_PURGE)
                        state_next = S_SH_READ;
                    else
                        state_next = S_SC_READ;
                end
            S_BS_STEP:
            begin
                ctl.cmd    = skt_pkg::CMD_BS_STEP;
                state_next = S_BS_READ;
            end
            S_SH_READ:
                if (!sts.sh_done)
                begin
                    ctl.cmd    = skt_pkg::CMD_SH_READ;
                    state_next = S_SH_WRITE;
                end
                else if (sts.operation == skt_pkg::OP_INSERT)
                    state_next = S_INS;
                else
                begin
                    ctl.cmd    = skt_pkg::CMD_PURGE_END;
                    state_next = S_DONE;
                end
            S_SH_WRITE:
            begin
                ctl.cmd    = skt_pkg::CMD_SH_WRITE;
                state_next = S_SH_READ;
            end
            S_INS:
            begin
                ctl.cmd    = skt_pkg::CMD_INS_WRITE;
                state_next = S_DONE;
            end
            S_SC_READ:
                if (!sts.scan_done)
                begin
                    ctl.cmd    = skt_pkg::CMD_SCAN_READ;
                    state_next = S_SC_STEP;
                end
                else
                    state_next = S_DONE;
            S_SC_STEP:
            begin
                ctl.cmd    = skt_pkg::CMD_SCAN_STEP;
                state_next = S_SC_READ;
            end
            S_DONE:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // state and registered flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end
endmodule

// File: rtl/sorted_key_table_engine.sv
// sorted key table engine top level
// one item at a time: the next item is accepted the cycle after the result is taken
// a search reads the table once per halving step (at most 9 steps at depth 256); find runs one search
// insert searches, then shifts later keys up one place and writes the new key; purge and first_free run two searches,
// then purge moves each later key down and first_free scans the plan's keys, one key at a time
// reset clears key count and restores entry limits 1 and 999; table contents start undefined
module sorted_key_table_engine #(
    parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    skt_if.sink                       req,
    skt_if.source                     rsp,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [skt_pkg::NUM_W-1:0] cfg_data
);
    logic [skt_pkg::NUM_W-1:0] entry_min_reg;
    logic [skt_pkg::NUM_W-1:0] entry_max_reg;
    skt_pkg::ctl_t ctl;
    skt_pkg::sts_t sts;
    skt_pkg::rsp_t dp_rsp;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_min_reg <= skt_pkg::NUM_W'(1);
            entry_max_reg <= skt_pkg::NUM_W'(999);
        end
        else if (cfg_we)
        begin
            if (cfg_index == skt_pkg::REG_ENTRY_MIN)
                entry_min_reg <= cfg_data;
            else if (cfg_index == skt_pkg::REG_ENTRY_MAX)
                entry_max_reg <= cfg_data;
        end
    end

    skt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    skt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .req       (req.data),
        .entry_min (entry_min_reg),
        .entry_max (entry_max_reg),
        .rsp       (dp_rsp)
    );

    // result payload
    assign rsp.data = dp_rsp;
endmodule

// File: bench/sorted_key_table_engine_test.sv
// testbench for the sorted key table engine: directed and random operations against a predictor
`timescale 1ns / 100ps

module sorted_key_table_engine_test;

    localparam int CYCLE_LIMIT = 6000000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [skt_pkg::NUM_W-1:0] cfg_data;

    skt_if #(.T(skt_pkg::req_t)) req ();
    skt_if #(.T(skt_pkg::rsp_t)) rsp ();

    sorted_key_table_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [skt_pkg::KEY_W-1:0] model_keys [skt_pkg::TABLE_DEPTH];
    int unsigned model_count;
    int unsigned model_entry_min;
    int unsigned model_entry_max;

    skt_pkg::rsp_t pending_rsp [$];
    int error_count;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int unsigned cycle_count = 0;

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // first index whose key is not less than k
    function automatic int unsigned table_lower_bound(input int unsigned k);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = model_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (model_keys[mid] < k)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // compute expected result of one item and update the table copy
    function automatic skt_pkg::rsp_t table_apply(input skt_pkg::req_t item);
        skt_pkg::rsp_t r;
        int unsigned key;
        int unsigned p;
        int unsigned s;
        int unsigned e;
        int unsigned n;
        int unsigned f;
        r = '0;
        key = item.plan_number * 1000 + item.entry_number;
        if (item.operation == skt_pkg::OP_FIND || item.operation == skt_pkg::OP_INSERT)
        begin
            p = table_lower_bound(key);
            r.position = p[8:0];
            if (p < model_count && model_keys[p] == key)
            begin
                r.found = 1'b1;
                if (item.operation == skt_pkg::OP_INSERT)
                    r.status = skt_pkg::ST_DUP;
            end
            else if (item.operation == skt_pkg::OP_INSERT)
            begin
                if (model_count >= skt_pkg::TABLE_DEPTH)
                    r.status = skt_pkg::ST_FULL;
                else
                begin
                    for (int i = model_count; i > p; i--)
                        model_keys[i] = model_keys[i-1];
                    model_keys[p] = key[skt_pkg::KEY_W-1:0];
                    model_count++;
                end
            end
        end
        else
        begin
            s = table_lower_bound(item.plan_number * 1000 + 1);
            e = table_lower_bound((item.plan_number + 1) * 1000 + 1);
            if (item.operation == skt_pkg::OP_PURGE)
            begin
                n = e - s;
                for (int i = e; i < model_count; i++)
                    model_keys[i-n] = model_keys[i];
                model_count -= n;
                r.position = s[8:0];
                r.removed_count = n[8:0];
            end
            else
            begin
                f = 0;
                for (int i = s; i < e; i++)
                    if ((model_keys[i] % 1000) > (i - s + 1))
                    begin
                        f = i - s + 1;
                        break;
                    end
                if (f == 0)
                    f = e - s + 1;
                if (f < model_entry_min || f > model_entry_max)
                    f = 0;
                r.free_number = f[skt_pkg::NUM_W-1:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_rsp.size() == 0)
                    report_mismatch("unexpected item", 1, 0);
                else
                begin
                    skt_pkg::rsp_t w;
                    w = pending_rsp.pop_front();
                    if (rsp.data.found !== w.found)
                        report_mismatch("found", rsp.data.found, w.found);
                    if (rsp.data.position !== w.position)
                        report_mismatch("position", rsp.data.position, w.position);
                    if (rsp.data.status !== w.status)
                        report_mismatch("status", rsp.data.status, w.status);
                    if (rsp.data.removed_count !== w.removed_count)
                        report_mismatch("removed_count", rsp.data.removed_count,
                                        w.removed_count);
                    if (rsp.data.free_number !== w.free_number)
                        report_mismatch("free_number", rsp.data.free_number,
                                        w.free_number);
                end
            end
        end
    end

    // receiver stalls and long hold-off
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // send one item, with random idle before it
    task automatic send_item(input logic [1:0] op, input int plan, input int entry);
        skt_pkg::req_t item;
        item.operation = op;
        item.plan_number = plan[skt_pkg::NUM_W-1:0];
        item.entry_number = entry[skt_pkg::NUM_W-1:0];
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data <= item;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        pending_rsp.push_back(table_apply(item));
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[skt_pkg::NUM_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == skt_pkg::REG_ENTRY_MIN)
            model_entry_min = value & 10'h3ff;
        else
            model_entry_max = value & 10'h3ff;
    endtask

    // directed extremes and special cases
    task automatic test_directed();
        send_item(skt_pkg::OP_FIND, 0, 0);
        send_item(skt_pkg::OP_PURGE, 5, 0);
        send_item(skt_pkg::OP_FREE, 5, 0);
        send_item(skt_pkg::OP_INSERT, 5, 1);
        send_item(skt_pkg::OP_INSERT, 5, 2);
        send_item(skt_pkg::OP_INSERT, 5, 4);
        send_item(skt_pkg::OP_INSERT, 5, 4);
        send_item(skt_pkg::OP_FREE, 5, 0);
        send_item(skt_pkg::OP_INSERT, 5, 3);
        send_item(skt_pkg::OP_FREE, 5, 0);
        send_item(skt_pkg::OP_INSERT, 0, 0);
        send_item(skt_pkg::OP_INSERT, 999, 999);
        send_item(skt_pkg::OP_INSERT, 1023, 1023);
        send_item(skt_pkg::OP_INSERT, 6, 1000);
        send_item(skt_pkg::OP_FIND, 1023, 1023);
        send_item(skt_pkg::OP_FIND, 5, 3);
        send_item(skt_pkg::OP_FIND, 5, 0);
        send_item(skt_pkg::OP_FREE, 1023, 1023);
        send_item(skt_pkg::OP_PURGE, 5, 1023);
        send_item(skt_pkg::OP_PURGE, 1023, 0);
        send_item(skt_pkg::OP_PURGE, 12, 0);
        wait_drained();
    endtask

    // fill the table to the full limit, then purge it out
    task automatic test_full_table();
        for (int i = 0; i < skt_pkg::TABLE_DEPTH + 4; i++)
            send_item(skt_pkg::OP_INSERT, 10 + i / 100, i % 100 + 1);
        send_item(skt_pkg::OP_INSERT, 1, 1);
        send_item(skt_pkg::OP_FIND, 11, 50);
        send_item(skt_pkg::OP_FREE, 10, 0);
        send_item(skt_pkg::OP_FREE, 12, 0);
        for (int p = 10; p < 13; p++)
            send_item(skt_pkg::OP_PURGE, p, 0);
        wait_drained();
    endtask

    // random mix concentrated on a few plans with small entries
    task automatic test_random(input int count);
        int op;
        int plan;
        int entry;
        for (int i = 0; i < count; i++)
        begin
            op = $urandom_range(99);
            plan = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(7);
            entry = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(12);
            if (op < 50)
                send_item(skt_pkg::OP_INSERT, plan, entry);
            else if (op < 75)
                send_item(skt_pkg::OP_FIND, plan, entry);
            else if (op < 90)
                send_item(skt_pkg::OP_FREE, plan, $urandom_range(1023));
            else if (model_count > 150 || op < 93)
                send_item(skt_pkg::OP_PURGE, plan, $urandom_range(1023));
            else
                send_item(skt_pkg::OP_FIND, plan, entry);
        end
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 12; i++)
            send_item(skt_pkg::OP_INSERT, 3, $urandom_range(20));
        wait_drained();
    endtask

    task automatic test_limits();
        write_reg(skt_pkg::REG_ENTRY_MIN, 0);
        write_reg(skt_pkg::REG_ENTRY_MAX, 999);
        test_random(150);
        write_reg(skt_pkg::REG_ENTRY_MIN, 3);
        write_reg(skt_pkg::REG_ENTRY_MAX, 5);
        test_random(150);
        write_reg(skt_pkg::REG_ENTRY_MIN, 999);
        write_reg(skt_pkg::REG_ENTRY_MAX, 0);
        test_random(100);
        write_reg(skt_pkg::REG_ENTRY_MIN, 1023);
        write_reg(skt_pkg::REG_ENTRY_MAX, 1023);
        test_random(100);
        write_reg(skt_pkg::REG_ENTRY_MIN, 1);
        write_reg(skt_pkg::REG_ENTRY_MAX, 999);
    endtask

    initial
    begin
        rst_n = 1'b0;
        error_count = 0;
        hold_cycles = 0;
        send_idle_pct = 38;
        recv_idle_pct = 55;
        model_count = 0;
        model_entry_min = 1;
        model_entry_max = 999;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.data = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_backpressure();
        test_random(250);
        send_idle_pct = 55;
        recv_idle_pct = 38;
        test_limits();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(300);

        wait_drained();
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
